FILE: hdl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

  // Number of timers in the bank (1 to 256).
  localparam int TIMER_COUNT = 8;
  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int TICK_W = 16;
  localparam logic [TICK_W-1:0] PENDING_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STOP_WR,
    S_SWEEP,
    S_CHK_RD,
    S_CHK_WR
  } state_t;

  // One timer entry. Remaining never exceeds the reload range, so 16 bits hold it.
  typedef struct packed {
    logic [TICK_W-1:0] remaining;
    logic [TICK_W-1:0] reload_value;
    logic              expiry_mark;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: hdl/ptb_entry_ram.sv
// Timer entry memory: one write port, one registered read port, reset-cleared entries.
`timescale 1ns / 1ps
`default_nettype none
module ptb_entry_ram
  import ptb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  entry_t                 mem [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Entries not written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/periodic_timer_bank.sv
// Top level of the periodic timer bank: command sequencer and pending tick count.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown on done/expired for one cycle, which the receiver
// must take as it comes. Tick, start, and stop with an out-of-range index finish
// from the idle state; a valid stop reads the entry, then writes it back.
// A check with no pending ticks reads the indexed entry if in range, then writes
// it back with its mark cleared; a check with pending ticks first walks every timer entry
// through the single entry memory, one per cycle. The memory port sets that pace.
// Reset clears all entries at once; no clearing pass is needed.
module periodic_timer_bank
  import ptb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] timer_index,
  input  wire logic [15:0] interval_ticks,
  output logic             done,
  output logic             expired
);

  state_t state, state_next;

  logic [TICK_W-1:0] pending, pending_next;
  logic [TICK_W-1:0] delta, delta_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  cmd_index, cmd_index_next;
  logic              idx_ok, idx_ok_next;
  logic              done_next, expired_next;

  mem_req_t req;
  entry_t   rd_data;
  entry_t   swept;
  logic [TICK_W:0] diff;
  logic     accept;
  logic     in_range;
  op_t      op_in;

  ptb_entry_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign accept   = start && !busy;
  assign op_in    = op_t'(op);
  assign in_range = {1'b0, timer_index} < (TICK_W+1)'(TIMER_COUNT);

  // Sweep of the entry read: if running, subtract the ticks, reload at zero or below.
  always_comb begin
    swept = rd_data;
    diff  = {1'b0, rd_data.remaining} - {1'b0, delta};
    if (rd_data.reload_value != '0) begin
      if (diff[TICK_W] || diff[TICK_W-1:0] == '0) begin
        swept.remaining   = rd_data.reload_value;
        swept.expiry_mark = 1'b1;
      end else begin
        swept.remaining = diff[TICK_W-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_STOP:  state_next = in_range ? S_STOP_WR : S_IDLE;
            OP_CHECK: state_next = (pending != '0) ? S_SWEEP : S_CHK_RD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_STOP_WR: state_next = S_IDLE;
      S_SWEEP: begin
        if (cnt == IDX_W'(TIMER_COUNT - 1)) begin
          state_next = S_CHK_RD;
        end
      end
      S_CHK_RD: state_next = S_CHK_WR;
      S_CHK_WR: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs, memory requests and datapath updates.
  always_comb begin
    busy           = (state != S_IDLE);
    pending_next   = pending;
    delta_next     = delta;
    cnt_next       = cnt;
    cmd_index_next = cmd_index;
    idx_ok_next    = idx_ok;
    done_next      = 1'b0;
    expired_next   = 1'b0;
    req            = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_index_next = timer_index[IDX_W-1:0];
          idx_ok_next    = in_range;
          case (op_in)
            OP_TICK: begin
              // Saturate at the top of the count.
              if (pending != PENDING_MAX) begin
                pending_next = pending + 1'b1;
              end
              done_next = 1'b1;
            end
            OP_START: begin
              req.wr_en                = in_range;
              req.wr_addr              = timer_index[IDX_W-1:0];
              req.wr_data.remaining    = interval_ticks;
              req.wr_data.reload_value = interval_ticks;
              req.wr_data.expiry_mark  = 1'b0;
              done_next                = 1'b1;
            end
            OP_STOP: begin
              // Read the entry so remaining and the mark survive the write back.
              req.rd_en = in_range;
              req.rd_addr = timer_index[IDX_W-1:0];
              done_next = !in_range;
            end
            OP_CHECK: begin
              delta_next   = pending;
              pending_next = '0;
              cnt_next     = '0;
              req.rd_en    = (pending != '0);
              req.rd_addr  = '0;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_STOP_WR: begin
        req.wr_en                = 1'b1;
        req.wr_addr              = cmd_index;
        req.wr_data              = rd_data;
        req.wr_data.reload_value = '0;
        done_next                = 1'b1;
      end
      S_SWEEP: begin
        // Write back entry cnt while reading the next one.
        req.wr_en   = 1'b1;
        req.wr_addr = cnt;
        req.wr_data = swept;
        if (cnt != IDX_W'(TIMER_COUNT - 1)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = cnt + 1'b1;
          cnt_next    = cnt + 1'b1;
        end
      end
      S_CHK_RD: begin
        req.rd_en   = idx_ok;
        req.rd_addr = cmd_index;
      end
      S_CHK_WR: begin
        req.wr_en               = idx_ok;
        req.wr_addr             = cmd_index;
        req.wr_data             = rd_data;
        req.wr_data.expiry_mark = 1'b0;
        expired_next            = idx_ok && rd_data.expiry_mark;
        done_next               = 1'b1;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= '0;
      done    <= 1'b0;
      expired <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      done    <= done_next;
      expired <= expired_next;
    end
  end

  // Hold the request fields; no reset needed.
  always_ff @(posedge clk) begin
    delta     <= delta_next;
    cnt       <= cnt_next;
    cmd_index <= cmd_index_next;
    idx_ok    <= idx_ok_next;
  end

endmodule
`default_nettype wire
